// ===== hdl/cfps_pkg.sv =====
// ----------------------------------------------------------------------------
// cfps_pkg
// Shared types and constants for the colored free page stack cache:
// request and response words, action and outcome codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cfps_pkg;

   // geometry
   localparam int NUM_LISTS   = 4;
   localparam int NUM_COLORS  = 8;
   localparam int STACK_DEPTH = 7;
   localparam int FILL_LIMIT  = 6;
   localparam int PAGE_BITS   = 32;

   localparam int NUM_STACKS  = NUM_LISTS * NUM_COLORS;
   localparam int STACK_BITS  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int MEM_WORDS   = NUM_STACKS * STACK_DEPTH;
   localparam int ADDR_BITS   = $clog2(MEM_WORDS);

   typedef logic [STACK_BITS-1:0] stack_type;
   typedef logic [DEPTH_BITS-1:0] depth_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [31:0]           word32_type;

   // request action codes
   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_FILL  = 2'd2,
      ACT_DRAIN = 2'd3
   } action_type;

   // response outcome codes
   typedef enum logic [2:0] {
      OC_NONE   = 3'd0,
      OC_GRANT  = 3'd1,
      OC_SPILL  = 3'd2,
      OC_ACCEPT = 3'd3,
      OC_REJECT = 3'd4
   } outcome_type;

   // request word
   typedef struct packed {
      action_type  action;
      logic [1:0]  list_index;
      logic [2:0]  color;
      logic [31:0] page;
   } req_type;

   // response word
   typedef struct packed {
      outcome_type outcome;
      logic [31:0] page_out;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic grant;
      logic spill;
      logic push;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic alloc_hit;
      logic spill_start;
      logic spill_done;
      logic is_free;
   } sts_type;

endpackage

// ===== hdl/colored_free_page_stack_cache.sv =====
// ----------------------------------------------------------------------------
// colored_free_page_stack_cache
// Per list and color stacks of free page numbers: alloc pops, free pushes
// (spilling a full stack first), fill takes offered pages, drain spills.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start and not busy
//   response  rsp_strobe, rsp_data           one cycle per word, no stall
//   register  csr_valid, csr_ready, csr_data write when valid and ready
//
// Miss, reject, accept and empty drain: execute, then back to idle.
// Alloc hit: execute, then grant, waiting on the registered page memory read.
// Spill of n pages: execute, then spill, and for a free of a full stack a
// push after; one memory read per spilled page.
// Reset clears the depths and the enable; page memory needs no clearing.
// The receiver cannot stall; each response word appears for one cycle.
// ----------------------------------------------------------------------------
module colored_free_page_stack_cache (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cfps_pkg::req_type req_data,
   output logic              rsp_strobe,
   output cfps_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   cfps_pkg::cmd_type cmd;
   cfps_pkg::sts_type sts;

   // sequencer
   cfps_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // storage and response
   cfps_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // an accepted word keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   // responses only follow work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a word in progress");

   // the last response frees the block
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> !busy)
      else $error("block still busy on the last response");

   // more responses pending keeps the block busy
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("block idle while responses are pending");
`endif

endmodule

// ===== hdl/cfps_controller.sv =====
// ----------------------------------------------------------------------------
// cfps_controller
// Sequencer for one request: capture, execute, then either finish, wait
// for a popped page, or spill a stack one entry per cycle, then push a free.
// ----------------------------------------------------------------------------
module cfps_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output cfps_pkg::cmd_type cmd,
   input  cfps_pkg::sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_GRANT = 5'b00100,
      ST_SPILL = 5'b01000,
      ST_PUSH  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.alloc_hit) begin
               state_in = ST_GRANT;
            end else if (sts.spill_start) begin
               state_in = ST_SPILL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GRANT: begin
            cmd.grant = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SPILL: begin
            cmd.spill = 1'b1;
            if (sts.spill_done) begin
               state_in = sts.is_free ? ST_PUSH : ST_IDLE;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/cfps_datapath.sv =====
// ----------------------------------------------------------------------------
// cfps_datapath
// Stack depths, page memory, enable register, request capture and the
// response register. Acts on controller commands and reports status.
// ----------------------------------------------------------------------------
module cfps_datapath (
   input  logic              clock,
   input  logic              reset,
   input  cfps_pkg::cmd_type cmd,
   output cfps_pkg::sts_type sts,
   input  cfps_pkg::req_type req_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data,
   output logic              rsp_strobe,
   output cfps_pkg::rsp_type rsp_data
);

   logic                   enable_ff;
   cfps_pkg::action_type   act_ff;
   cfps_pkg::stack_type    stack_ff;
   cfps_pkg::page_type     page_ff;
   logic                   ok_ff;
   cfps_pkg::depth_type    rem_ff;
   cfps_pkg::depth_type    rem_in;
   cfps_pkg::depth_type    depth_ff [cfps_pkg::NUM_STACKS];
   cfps_pkg::page_type     page_mem [cfps_pkg::MEM_WORDS];
   cfps_pkg::page_type     rdata_ff;
   logic                   rsp_strobe_ff;
   cfps_pkg::rsp_type      rsp_data_ff;

   logic                   req_ok;
   cfps_pkg::stack_type    req_stack;
   cfps_pkg::depth_type    depth_cur;
   cfps_pkg::depth_type    depth_new;
   logic                   depth_we;
   cfps_pkg::addr_type     base;
   logic                   use_ok;
   logic                   rd_en;
   cfps_pkg::addr_type     rd_addr;
   logic                   wr_en;
   cfps_pkg::addr_type     wr_addr;
   logic                   emit;
   cfps_pkg::rsp_type      emit_word;

   // register port always open
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_data;
      end
   end

   // address check and stack index of the incoming word
   assign req_ok = (int'(req_data.list_index) < cfps_pkg::NUM_LISTS) &&
                   (int'(req_data.color) < cfps_pkg::NUM_COLORS);
   assign req_stack = req_ok ?
      cfps_pkg::stack_type'(int'(req_data.list_index) * cfps_pkg::NUM_COLORS +
                            int'(req_data.color)) : '0;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_data.action;
         stack_ff <= req_stack;
         page_ff  <= cfps_pkg::page_type'(req_data.page);
         ok_ff    <= req_ok;
      end
   end

   assign depth_cur = depth_ff[stack_ff];
   assign base      = cfps_pkg::addr_type'(int'(stack_ff) * cfps_pkg::STACK_DEPTH);
   assign use_ok    = ok_ff && enable_ff;

   // command decode
   always_comb begin
      rd_en           = 1'b0;
      rd_addr         = base;
      wr_en           = 1'b0;
      wr_addr         = base;
      depth_we        = 1'b0;
      depth_new       = depth_cur;
      rem_in          = rem_ff;
      emit            = 1'b0;
      emit_word       = '{outcome: cfps_pkg::OC_NONE, page_out: '0, last: 1'b1};
      sts.alloc_hit   = 1'b0;
      sts.spill_start = 1'b0;
      sts.spill_done  = (rem_ff == '0);
      sts.is_free     = (act_ff == cfps_pkg::ACT_FREE);

      if (cmd.exec) begin
         unique case (act_ff)
            cfps_pkg::ACT_ALLOC: begin
               if (use_ok && depth_cur != '0) begin
                  rd_en         = 1'b1;
                  rd_addr       = base + cfps_pkg::addr_type'(depth_cur) -
                                  cfps_pkg::addr_type'(1);
                  depth_we      = 1'b1;
                  depth_new     = depth_cur - cfps_pkg::depth_type'(1);
                  sts.alloc_hit = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end
            cfps_pkg::ACT_FREE: begin
               if (use_ok && int'(depth_cur) >= cfps_pkg::STACK_DEPTH) begin
                  // full stack: spill all, then push onto the empty stack
                  rd_en           = 1'b1;
                  rd_addr         = base + cfps_pkg::addr_type'(depth_cur) -
                                    cfps_pkg::addr_type'(1);
                  rem_in          = depth_cur - cfps_pkg::depth_type'(1);
                  depth_we        = 1'b1;
                  depth_new       = cfps_pkg::depth_type'(1);
                  sts.spill_start = 1'b1;
               end else if (use_ok) begin
                  wr_en     = 1'b1;
                  wr_addr   = base + cfps_pkg::addr_type'(depth_cur);
                  depth_we  = 1'b1;
                  depth_new = depth_cur + cfps_pkg::depth_type'(1);
                  emit      = 1'b1;
                  emit_word.outcome  = cfps_pkg::OC_ACCEPT;
                  emit_word.page_out = cfps_pkg::word32_type'(page_ff);
               end else begin
                  emit = 1'b1;
                  emit_word.outcome  = cfps_pkg::OC_REJECT;
                  emit_word.page_out = cfps_pkg::word32_type'(page_ff);
               end
            end
            cfps_pkg::ACT_FILL: begin
               emit = 1'b1;
               emit_word.page_out = cfps_pkg::word32_type'(page_ff);
               if (use_ok && int'(depth_cur) < cfps_pkg::FILL_LIMIT &&
                   int'(depth_cur) < cfps_pkg::STACK_DEPTH) begin
                  wr_en     = 1'b1;
                  wr_addr   = base + cfps_pkg::addr_type'(depth_cur);
                  depth_we  = 1'b1;
                  depth_new = depth_cur + cfps_pkg::depth_type'(1);
                  emit_word.outcome = cfps_pkg::OC_ACCEPT;
               end else begin
                  emit_word.outcome = cfps_pkg::OC_REJECT;
               end
            end
            cfps_pkg::ACT_DRAIN: begin
               // drain ignores the enable
               if (ok_ff && depth_cur != '0) begin
                  rd_en           = 1'b1;
                  rd_addr         = base + cfps_pkg::addr_type'(depth_cur) -
                                    cfps_pkg::addr_type'(1);
                  rem_in          = depth_cur - cfps_pkg::depth_type'(1);
                  depth_we        = 1'b1;
                  depth_new       = '0;
                  sts.spill_start = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end
            default: begin
               emit = 1'b1;
            end
         endcase
      end

      // popped page is back from memory
      if (cmd.grant) begin
         emit = 1'b1;
         emit_word.outcome  = cfps_pkg::OC_GRANT;
         emit_word.page_out = cfps_pkg::word32_type'(rdata_ff);
      end

      // one spilled page per cycle, next read issued behind it
      if (cmd.spill) begin
         emit = 1'b1;
         emit_word.outcome  = cfps_pkg::OC_SPILL;
         emit_word.page_out = cfps_pkg::word32_type'(rdata_ff);
         emit_word.last     = (rem_ff == '0) && (act_ff != cfps_pkg::ACT_FREE);
         if (rem_ff != '0) begin
            rd_en   = 1'b1;
            rd_addr = base + cfps_pkg::addr_type'(rem_ff) - cfps_pkg::addr_type'(1);
            rem_in  = rem_ff - cfps_pkg::depth_type'(1);
         end
      end

      // freed page lands at the bottom of the emptied stack
      if (cmd.push) begin
         wr_en   = 1'b1;
         wr_addr = base;
         emit    = 1'b1;
         emit_word.outcome  = cfps_pkg::OC_ACCEPT;
         emit_word.page_out = cfps_pkg::word32_type'(page_ff);
      end
   end

   // stack depths
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cfps_pkg::NUM_STACKS; i++) begin
            depth_ff[i] <= '0;
         end
      end else if (depth_we) begin
         depth_ff[stack_ff] <= depth_new;
      end
   end

   // spill counter
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   // page memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_addr] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= page_mem[rd_addr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_word;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
